@@ rtl/tcw_pkg.sv @@
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS        = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TEXT_ROWS      = SCREEN_ROWS - 1;
  localparam int CELL_COUNT     = COLUMNS * TEXT_ROWS;
  localparam int LAST_ROW_START = CELL_COUNT - COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CUR_W   = 11;
  localparam int POS_W   = 8;
  localparam int CELL_W  = CHAR_W + ATTR_W;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_SETC  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  // Character and attribute constants
  localparam logic [CHAR_W-1:0] SPACE_CHAR     = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'h08;
  localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h1E;

  // Controller to datapath
  typedef struct packed {
    logic item_ld;     // latch accepted request
    logic exec;        // act on latched request
    logic copy_rd;     // scroll copy: read sweep+COLUMNS
    logic fill_wr;     // blank the cell at the sweep pointer
    logic fill_init;   // blank with the reset attribute
    logic sw_clr;
    logic sw_set_last;
    logic sw_inc;
    logic out_ld;      // load result register
  } tcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scroll_need;
    logic            sw_end_fill;
    logic            sw_end_copy;
  } tcw_sts_t;

endpackage

@@ rtl/text_console_writer_unit.sv @@
// Channel   Dir  Handshake            Payload
// -------   ---  -------------------  ---------------------------------------------
// in_       in   in_tvalid/in_tready  tuser: op; tdata: char, cell_addr, col, row
// out_      out  out_tvalid/out_tready tdata: cursor, cell_char, cell_attr, scrolled
// cfg_      in   cfg_valid/cfg_ready  cfg_data: text attribute byte
//
// Put and set cursor latch, then execute; a read adds a state for the cell data;
// a clear sweeps all cells; a put that scrolls copies LAST_ROW_START cells, drains,
// then blanks one row; all go through the single write port of the cell memory.
// After reset a clearing pass blanks all CELL_COUNT (1920) cells, one per cycle,
// before in_tready rises; config writes are taken during it.
// One request is in flight; the result register lets the next request be taken
// while a result still waits on out_tready.
module text_console_writer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] char_code, [18:8] cell_addr, [26:19] col,
                                  // [34:27] row, [39:35] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [10:0] cursor, [18:11] cell_char, [26:19] cell_attr,
                                  // [27] scrolled, [31:28] zero
  // attribute register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  logic [CUR_W-1:0]  res_cursor;
  logic [CHAR_W-1:0] res_char;
  logic [ATTR_W-1:0] res_attr;
  logic              res_scrolled;

  // attribute register is always writable
  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tcw_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .attr_we       (cfg_valid),
    .attr_wdata    (cfg_data),
    .in_op         (in_tuser),
    .in_char_code  (in_tdata[7:0]),
    .in_cell_addr  (in_tdata[18:8]),
    .in_col        (in_tdata[26:19]),
    .in_row        (in_tdata[34:27]),
    .cmd           (cmd),
    .sts           (sts),
    .out_cursor    (res_cursor),
    .out_cell_char (res_char),
    .out_cell_attr (res_attr),
    .out_scrolled  (res_scrolled)
  );

  assign out_tdata = {4'b0000, res_scrolled, res_attr, res_char, res_cursor};

endmodule

@@ rtl/tcw_ctrl.sv @@
module tcw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_SCRL = 3'd4;
  localparam logic [2:0] S_SDRN = 3'd5;
  localparam logic [2:0] S_BLNK = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       out_free;

  assign out_free   = !out_vld_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.fill_wr   = 1'b1;
        cmd.fill_init = 1'b1;
        cmd.sw_inc    = 1'b1;
        if (sts.sw_end_fill) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.item_ld = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.op)
          OP_PUT, OP_SETC: begin
            if (sts.scroll_need) begin
              cmd.sw_clr = 1'b1;
              state_nxt  = S_SCRL;
            end else if (out_free) begin
              cmd.out_ld = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt = S_DONE;
            end
          end
          OP_CLEAR: begin
            cmd.sw_clr = 1'b1;
            state_nxt  = S_FILL;
          end
          default: state_nxt = S_DONE;  // read: data lands next cycle
        endcase
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        cmd.sw_inc  = 1'b1;
        if (sts.sw_end_fill) state_nxt = S_DONE;
      end
      S_SCRL: begin
        cmd.copy_rd = 1'b1;
        if (sts.sw_end_copy) begin
          cmd.sw_set_last = 1'b1;
          state_nxt       = S_SDRN;
        end else begin
          cmd.sw_inc = 1'b1;
        end
      end
      S_SDRN: state_nxt = S_BLNK;   // last copy write drains
      S_BLNK: begin
        cmd.fill_wr = 1'b1;
        cmd.sw_inc  = 1'b1;
        if (sts.sw_end_fill) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.out_ld) out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

@@ rtl/tcw_datapath.sv @@
module tcw_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          attr_we,
  input  logic [tcw_pkg::ATTR_W-1:0]    attr_wdata,
  input  logic [tcw_pkg::OP_W-1:0]      in_op,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::CUR_W-1:0]     in_cell_addr,
  input  logic [tcw_pkg::POS_W-1:0]     in_col,
  input  logic [tcw_pkg::POS_W-1:0]     in_row,
  input  tcw_pkg::tcw_cmd_t             cmd,
  output tcw_pkg::tcw_sts_t             sts,
  output logic [tcw_pkg::CUR_W-1:0]     out_cursor,
  output logic [tcw_pkg::CHAR_W-1:0]    out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]    out_cell_attr,
  output logic                          out_scrolled
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  logic [ATTR_W-1:0] text_attr_r;
  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] sw_r, sw_nxt;
  logic              cp_vld_r;
  logic [ADDR_W-1:0] cp_addr_r;
  logic [CELL_W-1:0] rd_data_r;
  logic              rd_ok_r;
  logic              scr_r;

  logic [OP_W-1:0]   op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [CUR_W-1:0]  addr_r;
  logic [POS_W-1:0]  col_in_r;
  logic [POS_W-1:0]  row_in_r;

  logic [CUR_W-1:0]  out_cursor_r;
  logic [CELL_W-1:0] out_cell_r;
  logic              out_scr_r;

  logic [COL_W-1:0]  col_cl;
  logic [ROW_W-1:0]  row_cl;
  logic              addr_ok;
  logic              scr_need;
  logic              ex_we;
  logic [ADDR_W-1:0] ex_waddr;
  logic [CELL_W-1:0] ex_wdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              rd_en;
  logic [ADDR_W-1:0] raddr;
  logic [ATTR_W-1:0] fill_attr;

  assign col_cl  = (int'(col_in_r) > COLUMNS - 1) ? COL_W'(COLUMNS - 1) : COL_W'(col_in_r);
  assign row_cl  = (int'(row_in_r) > TEXT_ROWS - 1) ? ROW_W'(TEXT_ROWS - 1) : ROW_W'(row_in_r);
  assign addr_ok = int'(addr_r) < CELL_COUNT;

  // cursor update and the single cell write of a put
  always_comb begin
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    scr_need   = 1'b0;
    ex_we      = 1'b0;
    ex_waddr   = cursor_r;
    ex_wdata   = {text_attr_r, ch_r};
    if (cmd.exec) begin
      case (op_r)
        OP_PUT: begin
          if (ch_r == NEWLINE_CHAR) begin
            col_nxt = '0;
            if (cursor_r >= ADDR_W'(LAST_ROW_START)) begin
              scr_need   = 1'b1;
              cursor_nxt = ADDR_W'(LAST_ROW_START);
            end else begin
              cursor_nxt = cursor_r + ADDR_W'(COLUMNS) - ADDR_W'(col_r);
            end
          end else if (ch_r == BACKSPACE_CHAR) begin
            if (cursor_r != '0) begin
              cursor_nxt = cursor_r - ADDR_W'(1);
              col_nxt    = (col_r == '0) ? COL_W'(COLUMNS - 1) : col_r - COL_W'(1);
              ex_we      = 1'b1;
              ex_waddr   = cursor_r - ADDR_W'(1);
              ex_wdata   = {text_attr_r, SPACE_CHAR};
            end
          end else begin
            ex_we = 1'b1;
            if (cursor_r == ADDR_W'(CELL_COUNT - 1)) begin
              scr_need   = 1'b1;
              cursor_nxt = ADDR_W'(LAST_ROW_START);
              col_nxt    = '0;
            end else begin
              cursor_nxt = cursor_r + ADDR_W'(1);
              col_nxt    = (col_r == COL_W'(COLUMNS - 1)) ? '0 : col_r + COL_W'(1);
            end
          end
        end
        OP_SETC: begin
          cursor_nxt = ADDR_W'(row_cl) * ADDR_W'(COLUMNS) + ADDR_W'(col_cl);
          col_nxt    = col_cl;
        end
        OP_CLEAR: begin
          cursor_nxt = '0;
          col_nxt    = '0;
        end
        default: ;
      endcase
    end
  end

  // write port: pending scroll copy, then put, then sweep fill
  assign fill_attr = cmd.fill_init ? RESET_ATTR : text_attr_r;

  always_comb begin
    we    = 1'b0;
    waddr = sw_r;
    wdata = {fill_attr, SPACE_CHAR};
    if (cp_vld_r) begin
      we    = 1'b1;
      waddr = cp_addr_r;
      wdata = rd_data_r;
    end else if (ex_we) begin
      we    = 1'b1;
      waddr = ex_waddr;
      wdata = ex_wdata;
    end else if (cmd.fill_wr) begin
      we = 1'b1;
    end
  end

  assign rd_en = cmd.copy_rd || (cmd.exec && (op_r == OP_READ) && addr_ok);
  assign raddr = cmd.copy_rd ? sw_r + ADDR_W'(COLUMNS) : ADDR_W'(addr_r);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rd_data_r <= mem[raddr];
  end

  always_comb begin
    sw_nxt = sw_r;
    if (cmd.sw_clr) sw_nxt = '0;
    else if (cmd.sw_set_last) sw_nxt = ADDR_W'(LAST_ROW_START);
    else if (cmd.sw_inc) sw_nxt = sw_r + ADDR_W'(1);
  end

  assign sts.op          = op_r;
  assign sts.scroll_need = scr_need;
  assign sts.sw_end_fill = (sw_r == ADDR_W'(CELL_COUNT - 1));
  assign sts.sw_end_copy = (sw_r == ADDR_W'(LAST_ROW_START - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= RESET_ATTR;
      cursor_r    <= '0;
      col_r       <= '0;
      sw_r        <= '0;
      cp_vld_r    <= 1'b0;
      scr_r       <= 1'b0;
      rd_ok_r     <= 1'b0;
    end else begin
      if (attr_we) text_attr_r <= attr_wdata;
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
      sw_r     <= sw_nxt;
      cp_vld_r <= cmd.copy_rd;
      if (cmd.item_ld) scr_r <= 1'b0;
      else if (scr_need) scr_r <= 1'b1;
      if (cmd.exec) rd_ok_r <= addr_ok;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r <= sw_r;
    if (cmd.item_ld) begin
      op_r     <= in_op;
      ch_r     <= in_char_code;
      addr_r   <= in_cell_addr;
      col_in_r <= in_col;
      row_in_r <= in_row;
    end
    if (cmd.out_ld) begin
      out_cursor_r <= CUR_W'(cursor_nxt);
      out_cell_r   <= ((op_r == OP_READ) && rd_ok_r) ? rd_data_r : '0;
      out_scr_r    <= scr_r;
    end
  end

  assign out_cursor    = out_cursor_r;
  assign out_cell_char = out_cell_r[CHAR_W-1:0];
  assign out_cell_attr = out_cell_r[CELL_W-1:CHAR_W];
  assign out_scrolled  = out_scr_r;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import tcw_pkg::*;

  // Idle limit in cycles. A clear or a scrolling put keeps the block busy while it
  // sweeps the cell memory. Add the longest sink stall and the longest source
  // gap on top of that, then take it several times over.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 310;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // [7:0] char_code, [18:8] cell_addr, [26:19] col,
                                 // [34:27] row, [39:35] zero
  logic [1:0]  in_tuser = OP_PUT; // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [10:0] cursor, [18:11] cell_char, [26:19] cell_attr,
                                 // [27] scrolled, [31:28] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  // Result layout, low bits last in the declaration
  typedef struct packed {
    logic [3:0]        pad;
    logic              scrolled;
    logic [ATTR_W-1:0] cell_attr;
    logic [CHAR_W-1:0] cell_char;
    logic [CUR_W-1:0]  cursor;
  } console_result_t;

  // Shadow screen plus the queue of results still owed by the block
  class screen_scoreboard;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    int unsigned       cursor_lin;
    logic [ATTR_W-1:0] attr;
    console_result_t   pending[$];
    int unsigned       errors;

    function new();
      foreach (cells[i]) cells[i] = {RESET_ATTR, SPACE_CHAR};
      cursor_lin = 0;
      attr       = RESET_ATTR;
      errors     = 0;
    endfunction

    function void set_attr(logic [ATTR_W-1:0] value);
      attr = value;
    endfunction

    // Apply one accepted request to the shadow screen, queue its result
    function void note_request(logic [OP_W-1:0] op, logic [39:0] data);
      logic [CHAR_W-1:0] ch;
      logic [CUR_W-1:0]  addr;
      int unsigned       c;
      int unsigned       r;
      int unsigned       i;
      console_result_t   res;
      ch   = data[7:0];
      addr = data[18:8];
      c    = 32'(data[26:19]);
      r    = 32'(data[34:27]);
      res  = '0;
      case (op)
        OP_PUT: begin
          if (ch == NEWLINE_CHAR) begin
            cursor_lin += COLUMNS - (cursor_lin % COLUMNS);
          end else if (ch == BACKSPACE_CHAR) begin
            // backspace at home does nothing
            if (cursor_lin > 0) begin
              cursor_lin--;
              cells[cursor_lin] = {attr, SPACE_CHAR};
            end
          end else begin
            cells[cursor_lin] = {attr, ch};
            cursor_lin++;
          end
          // ran off the text area: move rows up, blank the last one
          if (cursor_lin >= CELL_COUNT) begin
            for (i = 0; i < LAST_ROW_START; i++) cells[i] = cells[i + COLUMNS];
            for (i = LAST_ROW_START; i < CELL_COUNT; i++) cells[i] = {attr, SPACE_CHAR};
            cursor_lin   = LAST_ROW_START;
            res.scrolled = 1'b1;
          end
        end
        OP_READ: begin
          // out-of-range reads return zero
          if (addr < CELL_COUNT) {res.cell_attr, res.cell_char} = cells[addr];
        end
        OP_SETC: begin
          if (c > COLUMNS - 1) c = COLUMNS - 1;
          if (r > TEXT_ROWS - 1) r = TEXT_ROWS - 1;
          cursor_lin = r * COLUMNS + c;
        end
        default: begin
          foreach (cells[j]) cells[j] = {attr, SPACE_CHAR};
          cursor_lin = 0;
        end
      endcase
      res.cursor = cursor_lin[CUR_W-1:0];
      pending.push_back(res);
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [31:0] data);
      console_result_t act;
      console_result_t exp;
      act = console_result_t'(data);
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected none, actual 0x%0h", $time, data);
        return;
      end
      exp = pending.pop_front();
      report("cursor", 32'(exp.cursor), 32'(act.cursor));
      report("cell_char", 32'(exp.cell_char), 32'(act.cell_char));
      report("cell_attr", 32'(exp.cell_attr), 32'(act.cell_attr));
      report("scrolled", 32'(exp.scrolled), 32'(act.scrolled));
      report("pad", 32'(exp.pad), 32'(act.pad));
    endfunction
  endclass

  screen_scoreboard sb = new();
  int unsigned      idle_cycles = 0;
  bit               quiet_stretch = 1'b0;  // no source gaps while set

  text_console_writer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Handshakes are sampled on pre-edge values; driver updates land after the
  // edge through nonblocking assignments, so the order here cannot race.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_attr(cfg_data);
      if (in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Watchdog: counts cycles with no handshake on any channel. The post-reset
  // clearing pass fits well inside the limit.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sink backpressure: bursts of ready, mostly short stalls, a few long ones,
  // and now and then a long stretch with no stall at all.
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    int unsigned pick;
    forever begin
      out_tready <= 1'b1;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
      repeat (run_len) @(posedge clk);
      pick = $urandom_range(0, 99);
      if (pick < 40) stall_len = 0;
      else if (pick < 95) stall_len = $urandom_range(1, 4);
      else stall_len = $urandom_range(20, 60);
      if (stall_len > 0) begin
        out_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (quiet_stretch || pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Drive one request. tvalid stays high after acceptance so a back-to-back
  // request needs only one assignment; in_idle() drops it when a burst ends.
  task automatic send_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                              logic [CUR_W-1:0] addr, logic [POS_W-1:0] col,
                              logic [POS_W-1:0] row);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, row, col, addr, ch};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic in_idle();
    in_tvalid <= 1'b0;
  endtask

  // Hold the source until every owed result is out; the block is then idle.
  // The first edge lets the monitor note a request accepted at the last edge.
  task automatic wait_drain();
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_attr(logic [ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random request. Unused fields carry random bits too. Set-cursor often
  // lands near the bottom so puts run into the scroll path.
  task automatic random_request();
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [CUR_W-1:0]  addr;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    int unsigned       pick;
    int unsigned       back;
    ch   = CHAR_W'($urandom_range(0, 255));
    addr = CUR_W'($urandom_range(0, 2047));
    col  = POS_W'($urandom_range(0, 255));
    row  = POS_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 999);
    if (pick < 620) begin
      op   = OP_PUT;
      pick = $urandom_range(0, 99);
      if (pick < 12) ch = NEWLINE_CHAR;
      else if (pick < 20) ch = BACKSPACE_CHAR;
    end else if (pick < 850) begin
      op   = OP_READ;
      pick = $urandom_range(0, 99);
      back = $urandom_range(0, 160);
      if (pick < 40 && sb.cursor_lin >= back) addr = CUR_W'(sb.cursor_lin - back);
      else if (pick < 85) addr = CUR_W'($urandom_range(0, CELL_COUNT - 1));
    end else if (pick < 990) begin
      op = OP_SETC;
      if ($urandom_range(0, 99) < 40) begin
        col = POS_W'($urandom_range(0, COLUMNS - 1));
        row = POS_W'($urandom_range(TEXT_ROWS - 3, TEXT_ROWS - 1));
      end
    end else begin
      op = OP_CLEAR;
    end
    send_request(op, ch, addr, col, row);
  endtask

  task automatic run_phase(int unsigned count);
    int unsigned n;
    for (n = 0; n < count; n++) begin
      // every 40 requests decide whether the next stretch runs gap-free
      if (n % 40 == 0) quiet_stretch = ($urandom_range(0, 4) == 0);
      random_request();
    end
    quiet_stretch = 1'b0;
    in_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // taken during the post-reset clearing pass, which still blanks with 0x1E
    write_attr(ATTR_W'($urandom_range(0, 255)));

    // Directed: reset contents, read range limits, put extremes, newline,
    // backspace at home and at the last cell, clamping, both scroll causes,
    // clear.
    send_request(OP_READ, 8'h00, 11'd0, 8'd0, 8'd0);
    send_request(OP_READ, 8'h00, CUR_W'(CELL_COUNT - 1), 8'd0, 8'd0);
    send_request(OP_READ, 8'h00, CUR_W'(CELL_COUNT), 8'd0, 8'd0);
    send_request(OP_READ, 8'h00, 11'h7FF, 8'hFF, 8'hFF);
    send_request(OP_PUT, 8'h00, 11'd0, 8'd0, 8'd0);
    send_request(OP_PUT, 8'hFF, 11'h7FF, 8'hFF, 8'hFF);
    send_request(OP_PUT, NEWLINE_CHAR, 11'd0, 8'd0, 8'd0);
    send_request(OP_PUT, BACKSPACE_CHAR, 11'd0, 8'd0, 8'd0);
    send_request(OP_READ, 8'h00, CUR_W'(COLUMNS - 1), 8'd0, 8'd0);
    send_request(OP_SETC, 8'h00, 11'd0, 8'd0, 8'd0);
    send_request(OP_PUT, BACKSPACE_CHAR, 11'd0, 8'd0, 8'd0);
    send_request(OP_SETC, 8'h00, 11'd0, 8'hFF, 8'hFF);
    send_request(OP_PUT, 8'h5A, 11'd0, 8'd0, 8'd0);
    send_request(OP_READ, 8'h00, CUR_W'(LAST_ROW_START - 1), 8'd0, 8'd0);
    send_request(OP_SETC, 8'h00, 11'd0, POS_W'(COLUMNS - 1), POS_W'(TEXT_ROWS - 1));
    send_request(OP_PUT, NEWLINE_CHAR, 11'd0, 8'd0, 8'd0);
    send_request(OP_PUT, NEWLINE_CHAR, 11'd0, 8'd0, 8'd0);
    send_request(OP_SETC, 8'h00, 11'd0, POS_W'(COLUMNS), POS_W'(TEXT_ROWS));
    send_request(OP_PUT, BACKSPACE_CHAR, 11'd0, 8'd0, 8'd0);
    send_request(OP_READ, 8'h00, CUR_W'(CELL_COUNT - 1), 8'd0, 8'd0);
    send_request(OP_CLEAR, 8'hFF, 11'h7FF, 8'hFF, 8'hFF);
    send_request(OP_READ, 8'h00, 11'd0, 8'd0, 8'd0);
    send_request(OP_READ, 8'h00, CUR_W'(CELL_COUNT - 1), 8'd0, 8'd0);
    in_idle();

    // Random phases, each under its own attribute; the source pauses for a
    // full drain before every attribute write.
    wait_drain();
    write_attr(8'h00);
    run_phase(ITEMS_PER_PHASE);
    wait_drain();
    write_attr(8'hFF);
    run_phase(ITEMS_PER_PHASE);
    wait_drain();
    write_attr(ATTR_W'($urandom_range(1, 254)));
    run_phase(ITEMS_PER_PHASE);
    wait_drain();
    write_attr(ATTR_W'($urandom_range(0, 255)));
    run_phase(ITEMS_PER_PHASE);

    wait_drain();
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0t: results outstanding, expected 0, actual %0d", $time, sb.pending.size());
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
